// ===== sv/scm_pkg.sv =====
// scm_pkg: shared types and constants for the share coordinate mapper.
// No dependencies; imported by every scm_* module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

  localparam int unsigned MaxHoldersDef = 16;
  localparam int unsigned MaxDepthDef   = 7;

  localparam int unsigned CoordW  = 28;
  localparam int unsigned OpW     = 2;
  localparam int unsigned HoldW   = 5;
  localparam int unsigned DepthW  = 3;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned PartsW  = 32;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned RegIdxW = 2;

  localparam logic [HoldW-1:0]  HoldersRst = 5'd5;
  localparam logic [DepthW-1:0] DepthRst   = 3'd2;
  localparam logic [IdxW-1:0]   OwnRst     = 4'd0;
  localparam logic [PartsW-1:0] PartsRst   = 32'h7654_3210;

  typedef enum logic [OpW-1:0] {
    OP_COMPRESS   = 2'd0,
    OP_DECOMPRESS = 2'd1,
    OP_REGEN      = 2'd2
  } scm_op_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_HOLDERS = 2'd0,
    REG_DEPTH   = 2'd1,
    REG_OWN     = 2'd2,
    REG_PARTS   = 2'd3
  } scm_reg_e;

  // effective (clamped) configuration
  typedef struct packed {
    logic [HoldW-1:0]  holders;
    logic [DepthW-1:0] depth;
    logic [IdxW-1:0]   own;
    logic [PartsW-1:0] parts;
  } scm_cfg_t;

  typedef struct packed {
    logic    valid;
    scm_op_e op;
  } scm_meta_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             none;
  } scm_flag_t;

endpackage

`default_nettype wire

// ===== sv/scm_digit_split.sv =====
// scm_digit_split: pipelined binary to base-N digit conversion, two input bits per stage.
// Depends on scm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scm_digit_split import scm_pkg::*; #(
  parameter int unsigned MAX_HOLDERS = MaxHoldersDef,
  parameter int unsigned MAX_DEPTH   = MaxDepthDef
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire scm_cfg_t                                          cfg_i,
  input  wire scm_meta_t                                         meta_i,
  input  wire logic [CoordW-1:0]                                 coord_i,
  output scm_meta_t                                              meta_o,
  output logic [MAX_DEPTH-1:0][$clog2(MAX_HOLDERS)-1:0]          digits_o
);

  localparam int unsigned DigitW = $clog2(MAX_HOLDERS);
  localparam int unsigned BaseW  = $clog2(MAX_HOLDERS + 1);
  localparam int unsigned VW     = BaseW + 2;
  localparam int unsigned Steps  = CoordW / 2;

  scm_meta_t                           meta_q [Steps];
  logic [BaseW-1:0]                    base_q [Steps];
  logic [CoordW-1:0]                   bits_q [Steps];
  logic [MAX_DEPTH-1:0][DigitW-1:0]    dig_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    scm_meta_t                        meta_in;
    logic [BaseW-1:0]                 base_in;
    logic [CoordW-1:0]                bits_in;
    logic [MAX_DEPTH-1:0][DigitW-1:0] dig_in;
    logic [MAX_DEPTH-1:0][DigitW-1:0] dig_d;
    logic [1:0]                       carry;
    logic [VW-1:0]                    v, b1, b2, b3;

    if (k == 0) begin : g_head
      assign meta_in = meta_i;
      assign base_in = (meta_i.op == OP_DECOMPRESS) ? BaseW'(cfg_i.holders - 5'd1)
                                                    : BaseW'(cfg_i.holders);
      assign bits_in = coord_i;
      assign dig_in  = '0;
    end else begin : g_body
      assign meta_in = meta_q[k-1];
      assign base_in = base_q[k-1];
      assign bits_in = bits_q[k-1];
      assign dig_in  = dig_q[k-1];
    end

    // digits = digits * 4 + two bits, carries ripple upward, top carry dropped
    always_comb begin
      carry = bits_in[CoordW-1 -: 2];
      b1    = VW'(base_in);
      b2    = b1 << 1;
      b3    = b1 + b2;
      v     = '0;
      dig_d = '0;
      for (int j = 0; j < MAX_DEPTH; j++) begin
        v = (VW'(dig_in[j]) << 2) + VW'(carry);
        if (v >= b3) begin
          dig_d[j] = DigitW'(v - b3);
          carry    = 2'd3;
        end else if (v >= b2) begin
          dig_d[j] = DigitW'(v - b2);
          carry    = 2'd2;
        end else if (v >= b1) begin
          dig_d[j] = DigitW'(v - b1);
          carry    = 2'd1;
        end else begin
          dig_d[j] = DigitW'(v);
          carry    = 2'd0;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else begin
        meta_q[k] <= meta_in;
      end
    end

    always_ff @(posedge clk_i) begin
      base_q[k] <= base_in;
      bits_q[k] <= bits_in << 2;
      dig_q[k]  <= dig_d;
    end
  end

  assign meta_o   = meta_q[Steps-1];
  assign digits_o = dig_q[Steps-1];

endmodule

`default_nettype wire

// ===== sv/scm_digit_map.sv =====
// scm_digit_map: holder search and digit shift, two register stages.
// Depends on scm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scm_digit_map import scm_pkg::*; #(
  parameter int unsigned MAX_HOLDERS = MaxHoldersDef,
  parameter int unsigned MAX_DEPTH   = MaxDepthDef
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire scm_cfg_t                                    cfg_i,
  input  wire scm_meta_t                                   meta_i,
  input  wire logic [MAX_DEPTH-1:0][$clog2(MAX_HOLDERS)-1:0] digits_i,
  output scm_meta_t                                        meta_o,
  output logic [MAX_DEPTH-1:0][$clog2(MAX_HOLDERS)-1:0]    digits_o,
  output scm_flag_t                                        flags_o
);

  localparam int unsigned DigitW = $clog2(MAX_HOLDERS);
  localparam int unsigned SlotN  = MAX_DEPTH + 1;

  // stage A: which slots are named by a digit, pick index and flags
  logic [SlotN-1:0] seen;
  logic             own_hit;
  logic             found;
  logic [SlotW-1:0] first;
  logic [IdxW-1:0]  idx_d;
  scm_flag_t        flags_d;

  always_comb begin
    seen    = '0;
    own_hit = 1'b0;
    found   = 1'b0;
    first   = '0;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (DepthW'(j) < cfg_i.depth) begin
        if (IdxW'(digits_i[j]) == cfg_i.own) own_hit = 1'b1;
        for (int s = 0; s < SlotN; s++) begin
          if (IdxW'(digits_i[j]) == cfg_i.parts[IdxW*s +: IdxW]) seen[s] = 1'b1;
        end
      end
    end
    for (int s = 0; s < SlotN; s++) begin
      if (!found && SlotW'(s) <= cfg_i.depth && !seen[s]) begin
        found = 1'b1;
        first = SlotW'(s);
      end
    end
    idx_d   = cfg_i.own;
    flags_d = '0;
    case (meta_i.op)
      OP_COMPRESS: begin
        flags_d.none = own_hit;
      end
      OP_DECOMPRESS: begin
        flags_d.none = 1'b0;
      end
      OP_REGEN: begin
        idx_d        = cfg_i.parts[IdxW*first +: IdxW];
        flags_d.slot = first;
        flags_d.none = !found;
      end
      default: begin
        flags_d.none = 1'b1;
      end
    endcase
  end

  scm_meta_t                        meta_a_q;
  logic [MAX_DEPTH-1:0][DigitW-1:0] dig_a_q;
  logic [IdxW-1:0]                  idx_a_q;
  scm_flag_t                        flags_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_a_q <= '0;
    end else begin
      meta_a_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_a_q   <= digits_i;
    idx_a_q   <= idx_d;
    flags_a_q <= flags_d;
  end

  // stage B: lower digits above the index, or raise digits from it upward
  logic [MAX_DEPTH-1:0][DigitW-1:0] dig_b_d;

  always_comb begin
    dig_b_d = dig_a_q;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (meta_a_q.op == OP_DECOMPRESS) begin
        if (IdxW'(dig_a_q[j]) >= idx_a_q) dig_b_d[j] = dig_a_q[j] + 1'b1;
      end else begin
        if (IdxW'(dig_a_q[j]) > idx_a_q) dig_b_d[j] = dig_a_q[j] - 1'b1;
      end
    end
  end

  scm_meta_t                        meta_b_q;
  logic [MAX_DEPTH-1:0][DigitW-1:0] dig_b_q;
  scm_flag_t                        flags_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_b_q <= '0;
    end else begin
      meta_b_q <= meta_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_b_q   <= dig_b_d;
    flags_b_q <= flags_a_q;
  end

  assign meta_o   = meta_b_q;
  assign digits_o = dig_b_q;
  assign flags_o  = flags_b_q;

endmodule

`default_nettype wire

// ===== sv/scm_digit_join.sv =====
// scm_digit_join: pipelined Horner recomposition, one digit and one multiply per stage.
// Depends on scm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scm_digit_join import scm_pkg::*; #(
  parameter int unsigned MAX_HOLDERS = MaxHoldersDef,
  parameter int unsigned MAX_DEPTH   = MaxDepthDef
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire scm_cfg_t                                      cfg_i,
  input  wire scm_meta_t                                     meta_i,
  input  wire logic [MAX_DEPTH-1:0][$clog2(MAX_HOLDERS)-1:0] digits_i,
  input  wire scm_flag_t                                     flags_i,
  output logic                                               done_o,
  output logic [CoordW-1:0]                                  coord_o,
  output logic [SlotW-1:0]                                   slot_o,
  output logic                                               none_o
);

  localparam int unsigned DigitW = $clog2(MAX_HOLDERS);
  localparam int unsigned BaseW  = $clog2(MAX_HOLDERS + 1);
  localparam int unsigned AccW   = CoordW + BaseW;

  scm_meta_t                        meta_q  [MAX_DEPTH];
  logic [MAX_DEPTH-1:0][DigitW-1:0] dig_q   [MAX_DEPTH];
  scm_flag_t                        flags_q [MAX_DEPTH];
  logic [CoordW-1:0]                sum_q   [MAX_DEPTH];

  for (genvar t = 0; t < MAX_DEPTH; t++) begin : g_stage
    localparam int unsigned Pos = MAX_DEPTH - 1 - t;

    scm_meta_t                        meta_in;
    logic [MAX_DEPTH-1:0][DigitW-1:0] dig_in;
    scm_flag_t                        flags_in;
    logic [CoordW-1:0]                sum_in;
    logic [CoordW-1:0]                sum_d;
    logic [BaseW-1:0]                 base;
    logic [AccW-1:0]                  acc;

    if (t == 0) begin : g_head
      assign meta_in  = meta_i;
      assign dig_in   = digits_i;
      assign flags_in = flags_i;
      assign sum_in   = '0;
    end else begin : g_body
      assign meta_in  = meta_q[t-1];
      assign dig_in   = dig_q[t-1];
      assign flags_in = flags_q[t-1];
      assign sum_in   = sum_q[t-1];
    end

    always_comb begin
      base = (meta_in.op == OP_DECOMPRESS) ? BaseW'(cfg_i.holders)
                                           : BaseW'(cfg_i.holders - 5'd1);
      acc  = AccW'(sum_in) * AccW'(base) + AccW'(dig_in[Pos]);
      if (flags_in.none) begin
        sum_d = '0;
      end else if (DepthW'(Pos) < cfg_i.depth) begin
        sum_d = acc[CoordW-1:0];
      end else begin
        sum_d = sum_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[t] <= '0;
      end else begin
        meta_q[t] <= meta_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dig_q[t]   <= dig_in;
      flags_q[t] <= flags_in;
      sum_q[t]   <= sum_d;
    end
  end

  assign done_o  = meta_q[MAX_DEPTH-1].valid;
  assign coord_o = sum_q[MAX_DEPTH-1];
  assign slot_o  = flags_q[MAX_DEPTH-1].slot;
  assign none_o  = flags_q[MAX_DEPTH-1].none;

endmodule

`default_nettype wire

// ===== sv/share_coordinate_mapper_top.sv =====
// share_coordinate_mapper_top: config registers and the split / map / join pipeline.
// Depends on scm_pkg, scm_digit_split, scm_digit_map, scm_digit_join.
//
//   channel   handshake              payload
//   -------   --------------------   --------------------------------------
//   command   start, busy            opcode_i, coord_in_i
//   result    done_o (strobe)        coord_out_o, part_slot_o, no_result_o
//   config    cfg_we_i, cfg_idx_i    cfg_wdata_i
//
// One transaction per cycle; busy is always low. Each result passes through 14 digit
// conversion stages, 2 map stages and one Horner stage per digit before done_o.
// Reset clears the config registers to their defaults and all stage valid bits.
// Results cannot be held off, so the pipeline never stalls.
`timescale 1ns / 1ps
`default_nettype none

module share_coordinate_mapper_top import scm_pkg::*; #(
  parameter int unsigned MAX_HOLDERS = MaxHoldersDef,
  parameter int unsigned MAX_DEPTH   = MaxDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OpW-1:0]      opcode_i,
  input  wire logic [CoordW-1:0]   coord_in_i,
  output logic                     done_o,
  output logic [CoordW-1:0]        coord_out_o,
  output logic [SlotW-1:0]         part_slot_o,
  output logic                     no_result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [PartsW-1:0]   cfg_wdata_i
);

  localparam int unsigned DigitW  = $clog2(MAX_HOLDERS);
  localparam int unsigned Latency = CoordW / 2 + 2 + MAX_DEPTH;

  logic [HoldW-1:0]  holders_q;
  logic [DepthW-1:0] depth_q;
  logic [IdxW-1:0]   own_q;
  logic [PartsW-1:0] parts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holders_q <= HoldersRst;
      depth_q   <= DepthRst;
      own_q     <= OwnRst;
      parts_q   <= PartsRst;
    end else if (cfg_we_i) begin
      case (scm_reg_e'(cfg_idx_i))
        REG_HOLDERS: holders_q <= cfg_wdata_i[HoldW-1:0];
        REG_DEPTH:   depth_q   <= cfg_wdata_i[DepthW-1:0];
        REG_OWN:     own_q     <= cfg_wdata_i[IdxW-1:0];
        REG_PARTS:   parts_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  scm_cfg_t cfg;

  always_comb begin
    cfg.own   = own_q;
    cfg.parts = parts_q;
    if (holders_q < 5'd2) begin
      cfg.holders = 5'd2;
    end else if (holders_q > HoldW'(MAX_HOLDERS)) begin
      cfg.holders = HoldW'(MAX_HOLDERS);
    end else begin
      cfg.holders = holders_q;
    end
    if (depth_q > DepthW'(MAX_DEPTH)) begin
      cfg.depth = DepthW'(MAX_DEPTH);
    end else begin
      cfg.depth = depth_q;
    end
  end

  assign busy = 1'b0;

  scm_meta_t in_meta;
  assign in_meta.valid = start && !busy;
  assign in_meta.op    = scm_op_e'(opcode_i);

  scm_meta_t                        split_meta, map_meta;
  logic [MAX_DEPTH-1:0][DigitW-1:0] split_dig, map_dig;
  scm_flag_t                        map_flags;

  scm_digit_split #(
    .MAX_HOLDERS (MAX_HOLDERS),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .meta_i   (in_meta),
    .coord_i  (coord_in_i),
    .meta_o   (split_meta),
    .digits_o (split_dig)
  );

  scm_digit_map #(
    .MAX_HOLDERS (MAX_HOLDERS),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .meta_i   (split_meta),
    .digits_i (split_dig),
    .meta_o   (map_meta),
    .digits_o (map_dig),
    .flags_o  (map_flags)
  );

  scm_digit_join #(
    .MAX_HOLDERS (MAX_HOLDERS),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_join (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .meta_i   (map_meta),
    .digits_i (map_dig),
    .flags_i  (map_flags),
    .done_o   (done_o),
    .coord_o  (coord_out_o),
    .slot_o   (part_slot_o),
    .none_o   (no_result_o)
  );

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Latency))
    else $error("result strobe without a matching start");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && no_result_o |-> coord_out_o == '0 && part_slot_o == '0)
    else $error("discarded transaction carries a nonzero payload");

  a_decomp_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(start && opcode_i == OP_DECOMPRESS, Latency) |-> !no_result_o)
    else $error("decompress transaction flagged as no result");

endmodule

`default_nettype wire

// ===== tb/share_coordinate_mapper_top_test.sv =====
`timescale 1ns / 1ps
// share_coordinate_mapper_top_test: self-checking bench for the share coordinate mapper.
// Drives corner-case and random commands under many register settings and checks each
// result against an in-bench model of the mapping. Needs scm_pkg and the RTL.
module share_coordinate_mapper_top_test;
  import scm_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned MaxHolders = MaxHoldersDef;
  localparam int unsigned MaxDepth   = MaxDepthDef;
  localparam int unsigned Latency    = CoordW / 2 + 2 + MaxDepth;
  localparam int unsigned StallLimit = 2000;
  localparam logic [CoordW-1:0] CoordMax = '1;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [CoordW-1:0] coord;
  } cmd_t;

  typedef struct packed {
    logic [CoordW-1:0] coord;
    logic [SlotW-1:0]  slot;
    logic              none;
  } map_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OpW-1:0]       opcode_i = '0;
  logic [CoordW-1:0]    coord_in_i = '0;
  logic                 done_o;
  logic [CoordW-1:0]    coord_out_o;
  logic [SlotW-1:0]     part_slot_o;
  logic                 no_result_o;
  logic                 cfg_we_i = 1'b0;
  logic [RegIdxW-1:0]   cfg_idx_i = '0;
  logic [PartsW-1:0]    cfg_wdata_i = '0;

  scm_cfg_t shadow_cfg = '{holders: HoldersRst, depth: DepthRst, own: OwnRst, parts: PartsRst};
  cmd_t cmd_q[$];
  map_t mapped_q[$];
  cmd_t next_cmd;
  map_t want;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_none = 0;
  int unsigned n_errors = 0;
  int unsigned n_settings = 0;
  int unsigned stall_cnt = 0;

  always #2 clk_i = ~clk_i;

  share_coordinate_mapper_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .coord_in_i (coord_in_i),
    .done_o     (done_o),
    .coord_out_o(coord_out_o),
    .part_slot_o(part_slot_o),
    .no_result_o(no_result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // packing: split base n, drop on idx, lower digits above idx, join base n-1
  // unpacking: split base n-1, raise digits >= idx, join base n
  function automatic bit remap_digits(input logic [CoordW-1:0] value, input int unsigned idx,
                                      input int unsigned n, input int d, input bit packing,
                                      output logic [CoordW-1:0] res);
    int unsigned dig[MaxDepth];
    int unsigned v, from_base, to_base, weight, sum;
    int i;
    v = 32'(value);
    res = '0;
    from_base = packing ? n : n - 1;
    to_base = packing ? n - 1 : n;
    for (i = d - 1; i >= 0; i--) begin
      dig[i] = v % from_base;
      v = v / from_base;
    end
    for (i = 0; i < d; i++) begin
      if (packing) begin
        if (dig[i] == idx) return 1'b0;
        if (dig[i] > idx) dig[i] = dig[i] - 1;
      end else if (dig[i] >= idx) begin
        dig[i] = dig[i] + 1;
      end
    end
    weight = 1;
    sum = 0;
    for (i = d - 1; i >= 0; i--) begin
      sum = sum + weight * dig[i];
      weight = weight * to_base;
    end
    res = sum[CoordW-1:0];
    return 1'b1;
  endfunction

  function automatic map_t map_coordinate(input cmd_t cmd, input scm_cfg_t cfg);
    map_t r;
    int unsigned n;
    int d;
    int s;
    logic [CoordW-1:0] c;
    r = '0;
    n = (cfg.holders < 2) ? 2 : ((cfg.holders > MaxHolders) ? MaxHolders : cfg.holders);
    d = (cfg.depth > MaxDepth) ? MaxDepth : cfg.depth;
    case (cmd.op)
      OP_COMPRESS: begin
        if (remap_digits(cmd.coord, 32'(cfg.own), n, d, 1'b1, c)) r.coord = c;
        else r.none = 1'b1;
      end
      OP_DECOMPRESS: begin
        void'(remap_digits(cmd.coord, 32'(cfg.own), n, d, 1'b0, c));
        r.coord = c;
      end
      OP_REGEN: begin
        r.none = 1'b1;
        for (s = 0; s <= d && r.none; s++) begin
          if (remap_digits(cmd.coord, 32'(cfg.parts[4*s +: 4]), n, d, 1'b1, c)) begin
            r.none = 1'b0;
            r.coord = c;
            r.slot = SlotW'(s);
          end
        end
      end
      default: r.none = 1'b1;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        mapped_q.push_back(map_coordinate(cmd_t'{op: opcode_i, coord: coord_in_i}, shadow_cfg));
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 &&
            !((n_sent < 200 || n_sent >= 330) && $urandom_range(0, 99) < 21)) begin
          next_cmd = cmd_q.pop_front();
          start <= 1'b1;
          opcode_i <= next_cmd.op;
          coord_in_i <= next_cmd.coord;
          n_sent++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (mapped_q.size() == 0) begin
        $error("unexpected result: coord_out %h part_slot %0d no_result %0b",
               coord_out_o, part_slot_o, no_result_o);
        n_errors++;
      end else begin
        want = mapped_q.pop_front();
        if (coord_out_o !== want.coord) begin
          $error("coord_out expected %h actual %h", want.coord, coord_out_o);
          n_errors++;
        end
        if (part_slot_o !== want.slot) begin
          $error("part_slot expected %0d actual %0d", want.slot, part_slot_o);
          n_errors++;
        end
        if (no_result_o !== want.none) begin
          $error("no_result expected %0b actual %0b", want.none, no_result_o);
          n_errors++;
        end
        if (want.none) n_none++;
        n_checked++;
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               stall_cnt, mapped_q.size());
      $display("[share_coordinate_mapper_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input scm_reg_e idx, input logic [PartsW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_HOLDERS: shadow_cfg.holders = data[HoldW-1:0];
      REG_DEPTH:   shadow_cfg.depth = data[DepthW-1:0];
      REG_OWN:     shadow_cfg.own = data[IdxW-1:0];
      default:     shadow_cfg.parts = data;
    endcase
  endtask

  task automatic set_cfg(input logic [PartsW-1:0] h, input logic [PartsW-1:0] d,
                         input logic [PartsW-1:0] o, input logic [PartsW-1:0] p);
    write_reg(REG_HOLDERS, h);
    write_reg(REG_DEPTH, d);
    write_reg(REG_OWN, o);
    write_reg(REG_PARTS, p);
    n_settings++;
  endtask

  task automatic drain;
    do @(negedge clk_i); while (cmd_q.size() != 0 || start || mapped_q.size() != 0);
  endtask

  task automatic push_cmd(input logic [OpW-1:0] op, input logic [CoordW-1:0] coord);
    cmd_q.push_back(cmd_t'{op: op, coord: coord});
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned h, n, d, o, base, k;
    longint unsigned bound;
    logic [PartsW-1:0] p;
    logic [OpW-1:0] op;
    logic [CoordW-1:0] c;
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
    n = (h < 2) ? 2 : ((h > MaxHolders) ? MaxHolders : h);
    d = $urandom_range(0, 7);
    o = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
    for (k = 0; k < 8; k++) begin
      p[4*k +: 4] = IdxW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, n - 1));
    end
    set_cfg(($urandom() << HoldW) | h, ($urandom() << DepthW) | d,
            ($urandom() << IdxW) | o, p);
    for (k = 0; k < count; k++) begin
      op = ($urandom_range(0, 49) == 0) ? OpUnused : OpW'($urandom_range(0, 2));
      base = (op == OP_DECOMPRESS) ? n - 1 : n;
      bound = 1;
      repeat (d) bound = bound * base;
      if ($urandom_range(0, 4) == 0 || bound > (longint'(1) << CoordW)) c = CoordW'($urandom());
      else c = CoordW'(longint'($urandom()) % bound);
      push_cmd(op, c);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    n_settings = 1;

    // reset settings: five holders, two digits, own index zero
    push_cmd(OP_COMPRESS, 28'd0);
    push_cmd(OP_COMPRESS, 28'd6);
    push_cmd(OP_COMPRESS, 28'd24);
    push_cmd(OP_COMPRESS, CoordMax);
    push_cmd(OP_DECOMPRESS, 28'd0);
    push_cmd(OP_DECOMPRESS, 28'd15);
    push_cmd(OP_REGEN, 28'd0);
    push_cmd(OpUnused, CoordMax);
    drain();

    // holder count below range, no digits, own index out of range
    set_cfg(32'd0, 32'd0, 32'd15, 32'h0000_0000);
    push_cmd(OP_COMPRESS, 28'd123);
    push_cmd(OP_DECOMPRESS, CoordMax);
    push_cmd(OP_REGEN, 28'd5);
    drain();

    // holder count above range, full depth
    set_cfg(32'd31, 32'd7, 32'd15, 32'hFEDC_BA98);
    push_cmd(OP_COMPRESS, CoordMax);
    push_cmd(OP_COMPRESS, 28'h012_3456);
    push_cmd(OP_DECOMPRESS, CoordMax);
    push_cmd(OP_REGEN, CoordMax);
    drain();

    // two holders: base one on decompress, regenerate with no part found
    set_cfg(32'd2, 32'd7, 32'd1, 32'h1111_1111);
    push_cmd(OP_DECOMPRESS, 28'h55);
    push_cmd(OP_COMPRESS, 28'h7F);
    push_cmd(OP_REGEN, 28'h7F);
    push_cmd(OP_REGEN, 28'd0);
    drain();

    // own index at or above holder count
    set_cfg(32'd3, 32'd4, 32'd7, 32'h0000_0210);
    push_cmd(OP_COMPRESS, 28'd80);
    push_cmd(OP_DECOMPRESS, 28'd15);
    push_cmd(OP_REGEN, 28'd40);
    drain();

    repeat (10) random_phase(55);

    repeat (Latency + 16) @(posedge clk_i);
    $display("covered %0d commands over %0d register settings", n_sent, n_settings);
    $display("checked %0d results, %0d of them with no result flagged", n_checked, n_none);
    if (n_errors == 0 && mapped_q.size() == 0) begin
      $display("[share_coordinate_mapper_top] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, mapped_q.size());
      $display("[share_coordinate_mapper_top] ERROR");
    end
    $finish;
  end

endmodule
